// File: rtl/core/irmfd_pkg.sv
// Shared types and constants for the IR Manchester frame decoder.
// No dependencies.
package irmfd_pkg;

  localparam int GapW   = 16;
  localparam int StateW = 3;
  localparam int CountW = 5;
  localparam int KeyW   = 6;
  localparam int CfgIdxW = 8;

  // Decoder states
  localparam logic [StateW-1:0] ST_IDLE  = 3'd0;
  localparam logic [StateW-1:0] ST_HEAD1 = 3'd1;
  localparam logic [StateW-1:0] ST_HEAD2 = 3'd2;
  localparam logic [StateW-1:0] ST_PH1   = 3'd3;
  localparam logic [StateW-1:0] ST_PH2   = 3'd4;
  localparam logic [StateW-1:0] ST_ERR   = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SHORT_MIN = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_SHORT_MAX = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_MIN  = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_LONG_MAX  = 8'd3;

  localparam logic [GapW-1:0] SHORT_MIN_RST = 16'd600;
  localparam logic [GapW-1:0] SHORT_MAX_RST = 16'd1200;
  localparam logic [GapW-1:0] LONG_MIN_RST  = 16'd1500;
  localparam logic [GapW-1:0] LONG_MAX_RST  = 16'd2000;

  // Frame check on a word zero-extended to 16 bits
  localparam logic [15:0] PREFIX_MASK = 16'h07c0;
  localparam logic [15:0] PREFIX_WANT = 16'h0700;

  localparam logic [CountW-1:0] COUNT_SAT = 5'd31;

  typedef struct packed {
    logic [GapW-1:0] half_lo;
    logic [GapW-1:0] half_hi;
    logic [GapW-1:0] full_lo;
    logic [GapW-1:0] full_hi;
  } cfg_t;

  typedef struct packed {
    logic timeout;     // above long window
    logic illegal;     // below short window or in the hole between windows
    logic in_short;
    logic in_long;
    logic over_short;  // above half_hi
  } gap_class_t;

endpackage

// File: rtl/core/irmfd_if.sv
// Handshake channel interfaces: edge events, decoded results, config writes.
// Depends on irmfd_pkg.
interface irmfd_in_if import irmfd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            level;
  logic [GapW-1:0] gap_us;

  modport source (output valid, level, gap_us, input ready);
  modport sink   (input valid, level, gap_us, output ready);
endinterface

interface irmfd_out_if import irmfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [StateW-1:0] fsm_state;
  logic [CountW-1:0] bit_count;
  logic              code_valid;
  logic [KeyW-1:0]   key_code;

  modport source (output valid, fsm_state, bit_count, code_valid, key_code, input ready);
  modport sink   (input valid, fsm_state, bit_count, code_valid, key_code, output ready);
endinterface

interface irmfd_cfg_if import irmfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [GapW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/irmfd_gap_class.sv
// Sorts an edge gap into the short/long/timeout/illegal windows.
// Depends on irmfd_pkg.
module irmfd_gap_class import irmfd_pkg::*; (
  input  logic [GapW-1:0] gap,
  input  cfg_t            cfg,
  output gap_class_t      cls
);

  logic ge_smin, le_smax, ge_lmin, le_lmax;

  always_comb begin
    ge_smin = gap >= cfg.half_lo;
    le_smax = gap <= cfg.half_hi;
    ge_lmin = gap >= cfg.full_lo;
    le_lmax = gap <= cfg.full_hi;

    cls.timeout    = !le_lmax;
    cls.illegal    = !ge_smin || (!le_smax && !ge_lmin);
    cls.in_short   = ge_smin && le_smax;
    cls.in_long    = ge_lmin && le_lmax;
    cls.over_short = !le_smax;
  end

endmodule

// File: rtl/core/ir_manchester_frame_decoder_core.sv
// IR Manchester (RC5-style) frame decoder, top level.
// Depends on irmfd_pkg, irmfd_if, irmfd_gap_class.
//
// Usage:
//   in_ch  : one beat per receiver edge: level after the edge (0 = active)
//            and gap_us, the microseconds since the previous edge.
//   out_ch : one beat per edge: state after the edge, bits decoded so far,
//            and code_valid/key_code when the edge closed a good frame.
//   cfg_ch : register writes (0 half_lo, 1 half_hi, 2 full_lo,
//            3 full_hi); other indexes are dropped. Always ready; write
//            only while no edge is in flight.
// Path: an accepted edge is registered in the input stage, then in the
//   result stage, which drives out_ch; two registers in all.
// Throughput: one edge per cycle while out_ch is not held. The state loop
//   (phase, bit count, shift word, prior level) closes through the window
//   compares and the next-state logic, with no register in between.
// Reset: rst_n low clears both stages, returns to idle with zero count and
//   word, line released, and loads the default windows 600/1200/1500/2000.
// Stall: while out_ch is held, the result stays put; one more edge can sit
//   in the input stage, after which in_ch.ready drops.
module ir_manchester_frame_decoder_core import irmfd_pkg::*; #(
  parameter int FRAME_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  irmfd_in_if.sink    in_ch,
  irmfd_out_if.source out_ch,
  irmfd_cfg_if.sink   cfg_ch
);

  // Configuration
  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_lo <= SHORT_MIN_RST;
      cfg_r.half_hi <= SHORT_MAX_RST;
      cfg_r.full_lo <= LONG_MIN_RST;
      cfg_r.full_hi <= LONG_MAX_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SHORT_MIN: cfg_r.half_lo <= cfg_ch.data;
        REG_SHORT_MAX: cfg_r.half_hi <= cfg_ch.data;
        REG_LONG_MIN:  cfg_r.full_lo <= cfg_ch.data;
        REG_LONG_MAX:  cfg_r.full_hi <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input stage
  logic            s1_valid_r;
  logic            s1_level_r;
  logic [GapW-1:0] s1_gap_r;
  logic            adv;

  // Result stage
  logic              out_valid_r;
  logic [StateW-1:0] out_state_r;
  logic [CountW-1:0] out_count_r;
  logic              out_code_valid_r;
  logic [KeyW-1:0]   out_key_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_level_r <= in_ch.level;
      s1_gap_r   <= in_ch.gap_us;
    end
  end

  // Decoder state
  logic [StateW-1:0]     phase_r, phase_nxt, phase_pre;
  logic [CountW-1:0]     bits_r, bits_nxt, bits_inc;
  logic [FRAME_BITS-1:0] word_r, word_nxt, word_shift;
  logic                  prior_r;
  logic                  code_valid;
  logic [KeyW-1:0]       key;
  logic [15:0]           word_ext;
  gap_class_t            cls;

  irmfd_gap_class u_gap_class (
    .gap (s1_gap_r),
    .cfg (cfg_r),
    .cls (cls)
  );

  always_comb begin
    bits_inc   = (bits_r == COUNT_SAT) ? bits_r : bits_r + 1'b1;
    word_shift = {word_r[FRAME_BITS-2:0], ~s1_level_r};

    // window violations override the current state before the step
    phase_pre = phase_r;
    if (cls.timeout) begin
      phase_pre = ST_IDLE;
    end else if (cls.illegal) begin
      phase_pre = s1_level_r ? ST_ERR : ST_IDLE;
    end

    phase_nxt  = phase_pre;
    bits_nxt   = bits_r;
    word_nxt   = word_r;
    code_valid = 1'b0;
    key        = '0;
    word_ext   = '0;

    unique case (phase_pre)
      ST_IDLE: begin
        if (!s1_level_r) phase_nxt = ST_HEAD1;
      end
      ST_HEAD1: begin
        if (cls.over_short)  phase_nxt = ST_ERR;
        else if (s1_level_r) phase_nxt = ST_HEAD2;
      end
      ST_HEAD2: begin
        if (cls.over_short) begin
          phase_nxt = ST_ERR;
        end else if (!s1_level_r) begin
          phase_nxt = ST_PH2;
          bits_nxt  = '0;
          word_nxt  = '0;
        end
      end
      ST_PH1, ST_PH2: begin
        if (s1_level_r != prior_r) begin
          if (cls.in_short) begin
            if (phase_pre == ST_PH2) begin
              phase_nxt = ST_PH1;
            end else begin
              phase_nxt = ST_PH2;
              bits_nxt  = bits_inc;
              word_nxt  = word_shift;
            end
          end else if (cls.in_long) begin
            if (phase_pre == ST_PH1) begin
              phase_nxt = ST_ERR;
            end else begin
              bits_nxt = bits_inc;
              word_nxt = word_shift;
            end
          end else begin
            phase_nxt = ST_ERR;
          end
        end
        // frame end check runs even if this edge just went to error
        word_ext = 16'(word_nxt);
        if (s1_level_r && bits_nxt == CountW'(FRAME_BITS)) begin
          if ((word_ext & PREFIX_MASK) == PREFIX_WANT) begin
            code_valid = 1'b1;
            key        = word_ext[KeyW-1:0];
            phase_nxt  = ST_IDLE;
          end else begin
            phase_nxt = ST_ERR;
          end
        end
      end
      default: begin
        if (s1_level_r) phase_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ST_IDLE;
      bits_r  <= '0;
      word_r  <= '0;
      prior_r <= 1'b1;
    end else if (s1_valid_r && adv) begin
      phase_r <= phase_nxt;
      bits_r  <= bits_nxt;
      word_r  <= word_nxt;
      prior_r <= s1_level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && adv) begin
      out_state_r      <= phase_nxt;
      out_count_r      <= bits_nxt;
      out_code_valid_r <= code_valid;
      out_key_r        <= key;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.fsm_state  = out_state_r;
  assign out_ch.bit_count  = out_count_r;
  assign out_ch.code_valid = out_code_valid_r;
  assign out_ch.key_code   = out_key_r;

endmodule

// File: rtl/core/irmfd_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on irmfd_pkg and ir_manchester_frame_decoder_core.
module irmfd_checker import irmfd_pkg::*; #(
  parameter int FRAME_BITS = 12
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [StateW-1:0] fsm_state,
  input logic [CountW-1:0] bit_count,
  input logic              code_valid,
  input logic [KeyW-1:0]   key_code
);

  // a good frame always drops the decoder back to idle
  a_code_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && code_valid |-> fsm_state == ST_IDLE)
    else $error("code_valid beat not in idle state");

  // a good frame has exactly the frame length in bits
  a_code_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && code_valid |-> bit_count == CountW'(FRAME_BITS))
    else $error("code_valid beat with wrong bit count");

  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !code_valid |-> key_code == '0)
    else $error("key_code nonzero without code_valid");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(fsm_state) && $stable(bit_count)
      && $stable(code_valid) && $stable(key_code))
    else $error("result beat changed while stalled");

endmodule

bind ir_manchester_frame_decoder_core irmfd_checker #(.FRAME_BITS(FRAME_BITS)) u_irmfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .fsm_state  (out_ch.fsm_state),
  .bit_count  (out_ch.bit_count),
  .code_valid (out_ch.code_valid),
  .key_code   (out_ch.key_code)
);
